// ----- design/crag_pkg.sv -----
// Shared types and widths for the column aggregate block.
`timescale 1ns / 1ps
`default_nettype none
package crag_pkg;

   localparam int unsigned CntW   = 17;
   localparam int unsigned SumW   = 48;
   localparam int unsigned SqSumW = 79;
   localparam int unsigned SmpW   = 32;
   localparam int unsigned ValW   = 64;
   localparam int unsigned ModeW  = 3;

   localparam logic [ModeW-1:0] MODE_SUM    = 3'd0;
   localparam logic [ModeW-1:0] MODE_MEAN   = 3'd1;
   localparam logic [ModeW-1:0] MODE_COUNT  = 3'd2;
   localparam logic [ModeW-1:0] MODE_MAX    = 3'd3;
   localparam logic [ModeW-1:0] MODE_MIN    = 3'd4;
   localparam logic [ModeW-1:0] MODE_STDDEV = 3'd5;

   // Totals of one closed set, handed from front to back.
   typedef struct packed {
      logic              dropped;
      logic [CntW-1:0]   cnt;
      logic [SumW-1:0]   sum;
      logic [SqSumW-1:0] sqsum;
      logic [SmpW-1:0]   min;
      logic [SmpW-1:0]   max;
   } set_type;

endpackage
`default_nettype wire

// ----- design/crag_front.sv -----
// Front end: takes samples, squares them and keeps the running totals of the set.
`timescale 1ns / 1ps
`default_nettype none
module crag_front #(
   parameter int unsigned MAX_COUNT = 65536
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           in_valid,
   output logic                          in_ready,
   input  wire  [crag_pkg::SmpW-1:0]     in_sample,
   input  wire                           in_has,
   input  wire                           in_last,
   output logic                          push_valid,
   output crag_pkg::set_type             push_data,
   input  wire                           push_full
);

   localparam logic [crag_pkg::CntW-1:0] CntMax = crag_pkg::CntW'(MAX_COUNT);

   logic                        p_valid_ff, p_valid_in;
   logic                        p_has_ff, p_last_ff;
   logic [crag_pkg::SmpW-1:0]   p_sample_ff;
   logic [2*crag_pkg::SmpW-1:0] p_sq_ff;

   logic [crag_pkg::CntW-1:0]   cnt_ff, cnt_in;
   logic [crag_pkg::SumW-1:0]   sum_ff, sum_in;
   logic [crag_pkg::SqSumW-1:0] sqsum_ff, sqsum_in;
   logic [crag_pkg::SmpW-1:0]   min_ff, min_in, max_ff, max_in;
   logic                        drop_ff, drop_in;

   logic [crag_pkg::SmpW-1:0]   mag;
   logic                        b_go, take;
   crag_pkg::set_type           tot;

   assign mag      = in_sample[crag_pkg::SmpW-1] ? (~in_sample + 1'b1) : in_sample;
   assign b_go     = !p_valid_ff || !p_last_ff || !push_full;
   assign in_ready = !p_valid_ff || b_go;
   assign take     = in_valid && in_ready;
   assign p_valid_in = take ? 1'b1 : (b_go ? 1'b0 : p_valid_ff);

   always_comb begin
      tot.cnt     = cnt_ff;
      tot.sum     = sum_ff;
      tot.sqsum   = sqsum_ff;
      tot.min     = min_ff;
      tot.max     = max_ff;
      tot.dropped = drop_ff;
      if (p_valid_ff && p_has_ff) begin
         if (cnt_ff < CntMax) begin
            tot.cnt   = cnt_ff + 1'b1;
            tot.sum   = sum_ff + {{(crag_pkg::SumW-crag_pkg::SmpW){p_sample_ff[crag_pkg::SmpW-1]}},
                                  p_sample_ff};
            tot.sqsum = sqsum_ff + {{(crag_pkg::SqSumW-2*crag_pkg::SmpW){1'b0}}, p_sq_ff};
            if (cnt_ff == '0 || $signed(p_sample_ff) < $signed(min_ff)) begin
               tot.min = p_sample_ff;
            end
            if (cnt_ff == '0 || $signed(p_sample_ff) > $signed(max_ff)) begin
               tot.max = p_sample_ff;
            end
         end else begin
            tot.dropped = 1'b1;
         end
      end
      push_valid = p_valid_ff && p_last_ff && !push_full;
      push_data  = tot;
      if (push_valid) begin
         cnt_in   = '0;
         sum_in   = '0;
         sqsum_in = '0;
         min_in   = '0;
         max_in   = '0;
         drop_in  = 1'b0;
      end else if (p_valid_ff && b_go) begin
         cnt_in   = tot.cnt;
         sum_in   = tot.sum;
         sqsum_in = tot.sqsum;
         min_in   = tot.min;
         max_in   = tot.max;
         drop_in  = tot.dropped;
      end else begin
         cnt_in   = cnt_ff;
         sum_in   = sum_ff;
         sqsum_in = sqsum_ff;
         min_in   = min_ff;
         max_in   = max_ff;
         drop_in  = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         cnt_ff     <= '0;
         sum_ff     <= '0;
         sqsum_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         drop_ff    <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         cnt_ff     <= cnt_in;
         sum_ff     <= sum_in;
         sqsum_ff   <= sqsum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         drop_ff    <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         p_sample_ff <= in_sample;
         p_has_ff    <= in_has;
         p_last_ff   <= in_last;
         p_sq_ff     <= mag * mag;
      end
   end

endmodule
`default_nettype wire

// ----- design/crag_fifo.sv -----
// Two-entry queue of closed set totals between front and back.
`timescale 1ns / 1ps
`default_nettype none
module crag_fifo (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  crag_pkg::set_type  push_data,
   output logic               full,
   input  wire                pop,
   output logic               pop_valid,
   output crag_pkg::set_type  pop_data
);

   crag_pkg::set_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = fill_ff == 2'd2;
   assign pop_valid = fill_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ff];
   assign wr_in     = push ? ~wr_ff : wr_ff;
   assign rd_in     = pop ? ~rd_ff : rd_ff;
   assign fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- design/crag_back.sv -----
// Back end: forms the selected aggregate with shift-add, root and divide steps.
`timescale 1ns / 1ps
`default_nettype none
module crag_back (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  [crag_pkg::ModeW-1:0]    mode,
   input  wire                           set_valid,
   input  crag_pkg::set_type             set_data,
   output logic                          set_pop,
   output logic                          out_valid,
   input  wire                           out_ready,
   output logic [crag_pkg::ValW-1:0]     out_value,
   output logic                          out_overflow
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MULN, ST_MULS, ST_SQRT, ST_DIV, ST_DONE
   } state_type;

   localparam int unsigned AccW = 96;
   localparam int unsigned MulW = crag_pkg::SumW;

   state_type                   state_ff;
   logic [crag_pkg::CntW-1:0]   cnt_ff;
   logic [MulW-1:0]             mag_ff;
   logic                        drop_ff, neg_ff;
   logic [AccW-1:0]             acc_ff, mcand_ff;
   logic [MulW-1:0]             mplier_ff;
   logic [5:0]                  step_ff;
   logic [127:0]                work_ff;
   logic [63:0]                 root_ff;
   logic [65:0]                 rem_ff;
   logic [crag_pkg::ValW-1:0]   res_ff;
   logic                        out_valid_ff;
   logic [crag_pkg::ValW-1:0]   out_value_ff;
   logic                        out_overflow_ff;

   logic [MulW-1:0]             in_mag;
   logic                        in_neg;
   logic [AccW-1:0]             acc_in;
   logic [65:0]                 rem_t, trial;
   logic                        sq_bit;
   logic [63:0]                 root_in;
   logic [crag_pkg::CntW:0]     div_t, div_d;
   logic                        q_bit;
   logic [63:0]                 quo_in;

   assign in_neg = set_data.sum[MulW-1];
   assign in_mag = in_neg ? (~set_data.sum + 1'b1) : set_data.sum;
   assign set_pop = (state_ff == ST_IDLE) && set_valid;

   always_comb begin
      acc_in = acc_ff;
      if (mplier_ff[0]) begin
         acc_in = (state_ff == ST_MULS) ? (acc_ff - mcand_ff) : (acc_ff + mcand_ff);
      end
      rem_t   = {rem_ff[63:0], work_ff[127:126]};
      trial   = {root_ff, 2'b01};
      sq_bit  = rem_t >= trial;
      root_in = {root_ff[62:0], sq_bit};
      div_t   = {rem_ff[crag_pkg::CntW-1:0], work_ff[63]};
      q_bit   = div_t >= {1'b0, cnt_ff};
      div_d   = q_bit ? (div_t - {1'b0, cnt_ff}) : div_t;
      quo_in  = {work_ff[62:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // in ST_DONE the output register is handled by the state itself
         if (out_valid_ff && out_ready && state_ff != ST_DONE) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (set_valid) begin
                  cnt_ff  <= set_data.cnt;
                  mag_ff  <= in_mag;
                  drop_ff <= set_data.dropped;
                  neg_ff  <= in_neg;
                  rem_ff  <= '0;
                  root_ff <= '0;
                  acc_ff  <= '0;
                  if (set_data.cnt == '0) begin
                     res_ff   <= '0;
                     state_ff <= ST_DONE;
                  end else begin
                     case (mode)
                        crag_pkg::MODE_SUM: begin
                           res_ff   <= {{(crag_pkg::ValW-MulW){in_neg}}, set_data.sum};
                           state_ff <= ST_DONE;
                        end
                        crag_pkg::MODE_COUNT: begin
                           res_ff   <= {{(crag_pkg::ValW-crag_pkg::CntW){1'b0}},
                                        set_data.cnt};
                           state_ff <= ST_DONE;
                        end
                        crag_pkg::MODE_MAX: begin
                           res_ff   <= {{(crag_pkg::ValW-crag_pkg::SmpW){set_data.max[31]}},
                                        set_data.max};
                           state_ff <= ST_DONE;
                        end
                        crag_pkg::MODE_MIN: begin
                           res_ff   <= {{(crag_pkg::ValW-crag_pkg::SmpW){set_data.min[31]}},
                                        set_data.min};
                           state_ff <= ST_DONE;
                        end
                        crag_pkg::MODE_MEAN: begin
                           work_ff  <= {64'd0, in_mag, 16'd0};
                           step_ff  <= 6'd63;
                           state_ff <= ST_DIV;
                        end
                        crag_pkg::MODE_STDDEV: begin
                           mcand_ff  <= {{(AccW-crag_pkg::SqSumW){1'b0}}, set_data.sqsum};
                           mplier_ff <= {{(MulW-crag_pkg::CntW){1'b0}}, set_data.cnt};
                           step_ff   <= 6'd47;
                           state_ff  <= ST_MULN;
                        end
                        default: begin
                           res_ff   <= '0;
                           state_ff <= ST_DONE;
                        end
                     endcase
                  end
               end
            end
            ST_MULN: begin
               acc_ff <= acc_in;
               if (step_ff == '0) begin
                  mcand_ff  <= {{(AccW-MulW){1'b0}}, mag_ff};
                  mplier_ff <= mag_ff;
                  step_ff   <= 6'd47;
                  state_ff  <= ST_MULS;
               end else begin
                  mcand_ff  <= {mcand_ff[AccW-2:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[MulW-1:1]};
                  step_ff   <= step_ff - 1'b1;
               end
            end
            ST_MULS: begin
               acc_ff <= acc_in;
               if (step_ff == '0) begin
                  // radicand is n*sumsq - sum^2, scaled by 2^32
                  work_ff  <= {acc_in, 32'd0};
                  step_ff  <= 6'd63;
                  state_ff <= ST_SQRT;
               end else begin
                  mcand_ff  <= {mcand_ff[AccW-2:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[MulW-1:1]};
                  step_ff   <= step_ff - 1'b1;
               end
            end
            ST_SQRT: begin
               root_ff <= root_in;
               if (step_ff == '0) begin
                  work_ff  <= {64'd0, root_in};
                  rem_ff   <= '0;
                  neg_ff   <= 1'b0;
                  step_ff  <= 6'd63;
                  state_ff <= ST_DIV;
               end else begin
                  rem_ff  <= sq_bit ? (rem_t - trial) : rem_t;
                  work_ff <= {work_ff[125:0], 2'b00};
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_DIV: begin
               rem_ff  <= {{(66-crag_pkg::CntW){1'b0}}, div_d[crag_pkg::CntW-1:0]};
               work_ff <= {64'd0, quo_in};
               if (step_ff == '0) begin
                  res_ff   <= neg_ff ? (~quo_in + 1'b1) : quo_in;
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_DONE: begin
               if (!out_valid_ff || out_ready) begin
                  out_valid_ff    <= 1'b1;
                  out_value_ff    <= res_ff;
                  out_overflow_ff <= drop_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_value    = out_value_ff;
   assign out_overflow = out_overflow_ff;

endmodule
`default_nettype wire

// ----- design/column_reduce_aggregate.sv -----
// Column aggregate: sum, mean, count, max, min or stddev of a stream of samples.
// Input items carry a signed 32-bit sample on req_tdata, a sample-present flag on
// req_tuser and the end of the set on req_tlast. An item with tlast closes the set:
// one result leaves on rsp_tdata (64-bit value) with the overflow flag on rsp_tuser.
// The front end takes one item per cycle when not stalled; the sample and its square
// are registered, then added to the totals. Closed sets wait in a two-entry queue for
// the back end. Back end work per set: sum, count, min and max need no steps; mean
// runs 64 divide steps (one quotient bit per cycle); stddev runs 48 + 48 shift-add steps
// for the radicand, 64 root and 64 divide steps. The front stalls only when a set
// closes while the queue is full. The result register holds a value until rsp_tready;
// a stalled receiver blocks the back end, not the front end, until the queue fills.
// csr_wr_en writes the mode (0 sum, 1 mean, 2 count, 3 max, 4 min, 5 stddev); change
// it only while the block is idle. Synchronous reset clears the totals, the queue,
// the result valid flag and the mode (sum). Sets beyond MAX_COUNT samples drop the
// extra samples and report overflow.
`timescale 1ns / 1ps
`default_nettype none
module column_reduce_aggregate #(
   parameter int unsigned MAX_COUNT = 65536
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [2:0]  csr_wr_data,   // mode
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,     // [31:0] sample
   input  wire         req_tuser,     // [0] has_sample
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,     // [63:0] value
   output logic        rsp_tuser      // [0] overflow
);

   logic [crag_pkg::ModeW-1:0] mode_ff;
   logic                       push, full, pop, pop_valid;
   crag_pkg::set_type          push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= crag_pkg::MODE_SUM;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   crag_front #(.MAX_COUNT(MAX_COUNT)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_sample(req_tdata), .in_has(req_tuser), .in_last(req_tlast),
      .push_valid(push), .push_data(push_data), .push_full(full)
   );

   crag_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(full),
      .pop(pop), .pop_valid(pop_valid), .pop_data(pop_data)
   );

   crag_back u_back (
      .clock(clock), .reset(reset), .mode(mode_ff),
      .set_valid(pop_valid), .set_data(pop_data), .set_pop(pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_value(rsp_tdata), .out_overflow(rsp_tuser)
   );

endmodule
`default_nettype wire
